FILE: sv/ipp_pkg.sv
// ipp_pkg: shared types, widths and constants of the projection profile block.
// Depends on nothing; used by ipp_front, ipp_back, the top level and the bench.
`timescale 1ns / 1ps

package ipp_pkg;

    localparam int PIX_W       = 10;
    localparam int TOTAL_W     = 20;
    localparam int VALUE_W     = 18;
    localparam int INDEX_W     = 10;
    localparam int CFG_DIM_W   = 11;

    // floor(x / 3) == (x * RECIP) >> RECIP_SHIFT for every x below 2**21
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP = 21'd1398102;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = TOTAL_W + RECIP_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int OBUF_DEPTH  = 8;
    localparam int OBUF_AW     = 3;
    localparam int OBUF_CW     = 4;
    localparam int CREDIT_W    = 5;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLOUR_MODE  = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic                 RST_COLOUR_MODE  = 1'b1;

    localparam logic AXIS_ROW    = 1'b0;
    localparam logic AXIS_COLUMN = 1'b1;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic row_end;
    } t_pix_flags;

    typedef struct packed {
        logic               valid;
        logic               axis;
        logic [INDEX_W-1:0] index;
        logic [TOTAL_W-1:0] sum;
        logic               last;
    } t_lane;

    typedef struct packed {
        logic               axis;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

endpackage

FILE: sv/ipp_ram.sv
// ipp_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module ipp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ipp_queue.sv
// ipp_queue: small register FIFO that decouples the classifier from the
// accumulator. No dependencies.
`timescale 1ns / 1ps

module ipp_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rdata = r_data[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (w_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: sv/ipp_front.sv
// ipp_front: pixel classifier. Sums the channels (grey: a only) and tracks the
// column and row, flagging row end, first and last row. Depends on ipp_pkg.
`timescale 1ns / 1ps

module ipp_front #(
    parameter int MAX_WIDTH  = ipp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ipp_pkg::DEF_MAX_HEIGHT,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_chan_a,
    input  logic [7:0]                     i_chan_b,
    input  logic [7:0]                     i_chan_c,
    input  logic [ipp_pkg::CFG_DIM_W-1:0]  i_frame_width,
    input  logic [ipp_pkg::CFG_DIM_W-1:0]  i_frame_height,
    input  logic                           i_colour_mode,
    output logic [ipp_pkg::PIX_W-1:0]      o_pix,
    output logic [CW-1:0]                  o_col,
    output logic [RW-1:0]                  o_row,
    output ipp_pkg::t_pix_flags            o_flags
);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [31:0]   w_width;
    logic [31:0]   w_height;

    always_comb begin
        if (i_frame_width == '0) begin
            w_width = 32'd1;
        end else if (32'(i_frame_width) > 32'(MAX_WIDTH)) begin
            w_width = 32'(MAX_WIDTH);
        end else begin
            w_width = 32'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            w_height = 32'd1;
        end else if (32'(i_frame_height) > 32'(MAX_HEIGHT)) begin
            w_height = 32'(MAX_HEIGHT);
        end else begin
            w_height = 32'(i_frame_height);
        end
    end

    assign o_pix = i_colour_mode
                 ? (ipp_pkg::PIX_W'(i_chan_a) + ipp_pkg::PIX_W'(i_chan_b)
                    + ipp_pkg::PIX_W'(i_chan_c))
                 : ipp_pkg::PIX_W'(i_chan_a);
    assign o_col = r_col;
    assign o_row = r_row;
    assign o_flags.first_row = (r_row == '0);
    assign o_flags.row_end   = (32'(r_col) + 32'd1 >= w_width);
    assign o_flags.last_row  = (32'(r_row) + 32'd1 >= w_height);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (o_flags.row_end) begin
                n_col = '0;
                n_row = o_flags.last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: sv/ipp_back.sv
// ipp_back: accumulator and result side. Column totals in ipp_ram, row total,
// divide by three in colour mode, output buffer. Depends on ipp_pkg, ipp_ram.
`timescale 1ns / 1ps

module ipp_back #(
    parameter int MAX_WIDTH  = ipp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ipp_pkg::DEF_MAX_HEIGHT,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  logic [ipp_pkg::PIX_W-1:0]    i_pix,
    input  logic [CW-1:0]                i_col,
    input  logic [RW-1:0]                i_row,
    input  ipp_pkg::t_pix_flags          i_flags,
    output logic                         o_q_pop,
    input  logic                         i_colour_mode,
    input  logic                         i_pop,
    output logic                         o_empty,
    output ipp_pkg::t_result             o_result
);

    localparam int TW = ipp_pkg::TOTAL_W;
    localparam int PW = ipp_pkg::PROD_W;

    // stage 1: memory read data arrives
    logic                       r_s1_valid;
    logic [ipp_pkg::PIX_W-1:0]  r_s1_pix;
    logic [CW-1:0]              r_s1_col;
    logic [RW-1:0]              r_s1_row;
    ipp_pkg::t_pix_flags        r_s1_flags;

    logic                       r_fw_valid;
    logic [CW-1:0]              r_fw_addr;
    logic [TW-1:0]              r_fw_data;
    logic [TW-1:0]              r_row_total;

    logic [TW-1:0]              w_rdata, w_mem_val, w_ctot, w_row_sum;

    ipp_pkg::t_lane             r_s2_c, r_s2_r, n_s2_c, n_s2_r;
    ipp_pkg::t_lane             r_s3_c, r_s3_r;
    logic [PW-1:0]              r_s3_c_prod, r_s3_r_prod;
    ipp_pkg::t_result           w_res_c, w_res_r;

    ipp_pkg::t_result           r_obuf [ipp_pkg::OBUF_DEPTH];
    logic [ipp_pkg::OBUF_AW-1:0] r_owp, r_orp;
    logic [ipp_pkg::OBUF_CW-1:0] r_ocount;
    logic [ipp_pkg::OBUF_AW-1:0] w_wp_r;
    logic [1:0]                 w_npush;
    logic                       w_opop;
    logic [ipp_pkg::CREDIT_W-1:0] w_need;

    // reserve output buffer room for every result still in flight
    assign w_need = ipp_pkg::CREDIT_W'(r_ocount)
                  + ipp_pkg::CREDIT_W'(r_s1_valid && r_s1_flags.last_row)
                  + ipp_pkg::CREDIT_W'(r_s1_valid && r_s1_flags.row_end)
                  + ipp_pkg::CREDIT_W'(r_s2_c.valid) + ipp_pkg::CREDIT_W'(r_s2_r.valid)
                  + ipp_pkg::CREDIT_W'(r_s3_c.valid) + ipp_pkg::CREDIT_W'(r_s3_r.valid)
                  + ipp_pkg::CREDIT_W'(i_flags.last_row)
                  + ipp_pkg::CREDIT_W'(i_flags.row_end);
    assign o_q_pop = !i_q_empty && (w_need <= ipp_pkg::CREDIT_W'(ipp_pkg::OBUF_DEPTH));

    ipp_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (w_ctot),
        .i_re    (o_q_pop),
        .i_raddr (i_col),
        .o_rdata (w_rdata)
    );

    // the write in the cycle of the read is not yet in the read data
    assign w_mem_val = (r_fw_valid && r_fw_addr == r_s1_col) ? r_fw_data : w_rdata;
    assign w_ctot    = r_s1_flags.first_row ? TW'(r_s1_pix) : w_mem_val + TW'(r_s1_pix);
    assign w_row_sum = r_row_total + TW'(r_s1_pix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_row_total <= '0;
        end else begin
            r_s1_valid <= o_q_pop;
            r_fw_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_row_total <= r_s1_flags.row_end ? '0 : w_row_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix   <= i_pix;
        r_s1_col   <= i_col;
        r_s1_row   <= i_row;
        r_s1_flags <= i_flags;
        r_fw_addr  <= r_s1_col;
        r_fw_data  <= w_ctot;
    end

    always_comb begin
        n_s2_c.valid = r_s1_valid && r_s1_flags.last_row;
        n_s2_c.axis  = ipp_pkg::AXIS_COLUMN;
        n_s2_c.index = ipp_pkg::INDEX_W'(r_s1_col);
        n_s2_c.sum   = w_ctot;
        n_s2_c.last  = !r_s1_flags.row_end;
        n_s2_r.valid = r_s1_valid && r_s1_flags.row_end;
        n_s2_r.axis  = ipp_pkg::AXIS_ROW;
        n_s2_r.index = ipp_pkg::INDEX_W'(r_s1_row);
        n_s2_r.sum   = w_row_sum;
        n_s2_r.last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_c.valid <= 1'b0;
            r_s2_r.valid <= 1'b0;
            r_s3_c.valid <= 1'b0;
            r_s3_r.valid <= 1'b0;
        end else begin
            r_s2_c <= n_s2_c;
            r_s2_r <= n_s2_r;
            r_s3_c <= r_s2_c;
            r_s3_r <= r_s2_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_c_prod <= PW'(r_s2_c.sum) * PW'(ipp_pkg::RECIP);
        r_s3_r_prod <= PW'(r_s2_r.sum) * PW'(ipp_pkg::RECIP);
    end

    always_comb begin
        w_res_c.axis  = r_s3_c.axis;
        w_res_c.index = r_s3_c.index;
        w_res_c.last  = r_s3_c.last;
        w_res_c.value = i_colour_mode
                      ? ipp_pkg::VALUE_W'(r_s3_c_prod >> ipp_pkg::RECIP_SHIFT)
                      : ipp_pkg::VALUE_W'(r_s3_c.sum);
        w_res_r.axis  = r_s3_r.axis;
        w_res_r.index = r_s3_r.index;
        w_res_r.last  = r_s3_r.last;
        w_res_r.value = i_colour_mode
                      ? ipp_pkg::VALUE_W'(r_s3_r_prod >> ipp_pkg::RECIP_SHIFT)
                      : ipp_pkg::VALUE_W'(r_s3_r.sum);
    end

    // output buffer: column entry goes ahead of the row entry
    assign w_npush  = 2'(r_s3_c.valid) + 2'(r_s3_r.valid);
    assign w_wp_r   = r_s3_c.valid ? r_owp + ipp_pkg::OBUF_AW'(1) : r_owp;
    assign o_empty  = (r_ocount == '0);
    assign w_opop   = i_pop && !o_empty;
    assign o_result = r_obuf[r_orp];

    always_ff @(posedge i_clk) begin
        if (r_s3_c.valid) begin
            r_obuf[r_owp] <= w_res_c;
        end
        if (r_s3_r.valid) begin
            r_obuf[w_wp_r] <= w_res_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocount <= '0;
        end else begin
            r_owp    <= r_owp + ipp_pkg::OBUF_AW'(w_npush);
            r_orp    <= r_orp + ipp_pkg::OBUF_AW'(w_opop);
            r_ocount <= r_ocount + ipp_pkg::OBUF_CW'(w_npush) - ipp_pkg::OBUF_CW'(w_opop);
        end
    end

endmodule

FILE: sv/image_projection_profile.sv
// image_projection_profile: top level. Register port, classifier, queue and
// accumulator. Depends on ipp_pkg, ipp_front, ipp_queue, ipp_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  pixel in | push / full          | i_chan_a, i_chan_b, i_chan_c
//  result   | pop / empty          | o_profile_axis, o_profile_index,
//           |                      | o_profile_value, o_last_of_run
//  config   | psel, penable, pwrite| paddr, pwdata, prdata (pready tied high)
//
// One pixel per cycle while results drain as fast as they come.
// Results pass the queue and back-end stage registers into the output buffer.
// The issue point in front of the column RAM admits a pixel only while the
// eight-entry output buffer has room for all results in flight; on the last row
// every pixel gives a column entry and a row end one more, so results outrun a
// consumer popping every cycle and the input stalls through full.
// Synchronous reset; the column RAM needs no clearing pass (first row writes it).
`timescale 1ns / 1ps

module image_projection_profile #(
    parameter int MAX_WIDTH  = ipp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ipp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_chan_a,
    input  logic [7:0]                         i_chan_b,
    input  logic [7:0]                         i_chan_c,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_profile_axis,
    output logic [ipp_pkg::INDEX_W-1:0]        o_profile_index,
    output logic [ipp_pkg::VALUE_W-1:0]        o_profile_value,
    output logic                               o_last_of_run,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ipp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ipp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ipp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW = $bits(ipp_pkg::t_pix_flags);
    localparam int QW = FW + RW + CW + ipp_pkg::PIX_W;

    logic [ipp_pkg::CFG_DIM_W-1:0] r_frame_width;
    logic [ipp_pkg::CFG_DIM_W-1:0] r_frame_height;
    logic                          r_colour_mode;
    logic                          w_cfg_wr;
    logic [ipp_pkg::REG_IDX_W-1:0] w_reg_idx;

    logic                          w_accept;
    logic [ipp_pkg::PIX_W-1:0]     w_f_pix, w_b_pix;
    logic [CW-1:0]                 w_f_col, w_b_col;
    logic [RW-1:0]                 w_f_row, w_b_row;
    ipp_pkg::t_pix_flags           w_f_flags, w_b_flags;
    logic [QW-1:0]                 w_q_wdata, w_q_rdata;
    logic                          w_q_pop, w_q_empty;
    ipp_pkg::t_result              w_result;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[ipp_pkg::REG_IDX_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ipp_pkg::RST_FRAME_WIDTH;
            r_frame_height <= ipp_pkg::RST_FRAME_HEIGHT;
            r_colour_mode  <= ipp_pkg::RST_COLOUR_MODE;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                ipp_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[ipp_pkg::CFG_DIM_W-1:0];
                ipp_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[ipp_pkg::CFG_DIM_W-1:0];
                ipp_pkg::REG_COLOUR_MODE:  r_colour_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            ipp_pkg::REG_FRAME_WIDTH:  prdata = ipp_pkg::APB_DATA_W'(r_frame_width);
            ipp_pkg::REG_FRAME_HEIGHT: prdata = ipp_pkg::APB_DATA_W'(r_frame_height);
            ipp_pkg::REG_COLOUR_MODE:  prdata = ipp_pkg::APB_DATA_W'(r_colour_mode);
            default:                   prdata = '0;
        endcase
    end

    assign w_accept = push && !full;

    ipp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_chan_a       (i_chan_a),
        .i_chan_b       (i_chan_b),
        .i_chan_c       (i_chan_c),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_colour_mode  (r_colour_mode),
        .o_pix          (w_f_pix),
        .o_col          (w_f_col),
        .o_row          (w_f_row),
        .o_flags        (w_f_flags)
    );

    assign w_q_wdata = {w_f_flags, w_f_row, w_f_col, w_f_pix};

    ipp_queue #(
        .WIDTH (QW),
        .DEPTH (ipp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_rdata (w_q_rdata),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    assign {w_b_flags, w_b_row, w_b_col, w_b_pix} = w_q_rdata;

    ipp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_pix         (w_b_pix),
        .i_col         (w_b_col),
        .i_row         (w_b_row),
        .i_flags       (w_b_flags),
        .o_q_pop       (w_q_pop),
        .i_colour_mode (r_colour_mode),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result      (w_result)
    );

    assign o_profile_axis  = w_result.axis;
    assign o_profile_index = w_result.index;
    assign o_profile_value = w_result.value;
    assign o_last_of_run   = w_result.last;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("back end took a transfer from an empty queue");

    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(w_accept))
        else $error("queue went full without a transfer in");

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for image_projection_profile (row and column profiles).
// Depends on ipp_pkg and image_projection_profile; a directed table, its entries partly typed out
// and partly predicted, then random frames, all scored against an in-bench profile predictor.
`timescale 1ns / 1ps

module tb_top;
    import ipp_pkg::*;

    localparam int MAX_COLS      = DEF_MAX_WIDTH;
    localparam int MAX_ROWS      = DEF_MAX_HEIGHT;
    localparam int RANDOM_PIXELS = 370;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic {STEP_CFG, STEP_PIX} step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [CFG_DIM_W-1:0]   reg_val;
        logic [7:0]             a;
        logic [7:0]             b;
        logic [7:0]             c;
        logic [1:0]             typed_n;   // 0: score with the predictor
        t_result                res0;
        t_result                res1;
    } dir_step_t;

    localparam t_result NO_ENTRY = '0;
    localparam int DIR_N = 36;

    localparam dir_step_t DIR_STEPS [DIR_N] = '{
        // 1x1 frames: width and height of zero act as one
        '{STEP_CFG, REG_FRAME_WIDTH,  11'd0, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_FRAME_HEIGHT, 11'd0, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_COLOUR_MODE,  11'd1, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 2'd2,
          '{AXIS_COLUMN, 10'd0, 18'd255, 1'b0}, '{AXIS_ROW, 10'd0, 18'd255, 1'b1}},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd0, 8'd0, 8'd0, 2'd2,
          '{AXIS_COLUMN, 10'd0, 18'd0, 1'b0}, '{AXIS_ROW, 10'd0, 18'd0, 1'b1}},
        // grey: only channel a counts
        '{STEP_CFG, REG_COLOUR_MODE,  11'd0, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd255, 8'd0, 8'd0, 2'd2,
          '{AXIS_COLUMN, 10'd0, 18'd255, 1'b0}, '{AXIS_ROW, 10'd0, 18'd255, 1'b1}},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd0, 8'd255, 8'd255, 2'd2,
          '{AXIS_COLUMN, 10'd0, 18'd0, 1'b0}, '{AXIS_ROW, 10'd0, 18'd0, 1'b1}},
        // 3x2 colour frame
        '{STEP_CFG, REG_FRAME_WIDTH,  11'd3, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_FRAME_HEIGHT, 11'd2, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_COLOUR_MODE,  11'd1, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd1, 8'd2, 8'd3, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd7, 8'd8, 8'd9, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd128, 8'd64, 8'd32, 2'd0, NO_ENTRY, NO_ENTRY},
        // 3x3 frame, mode then width changed mid-frame
        '{STEP_CFG, REG_FRAME_HEIGHT, 11'd3, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd10, 8'd20, 8'd30, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd40, 8'd50, 8'd60, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd70, 8'd80, 8'd90, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd200, 8'd100, 8'd50, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_COLOUR_MODE,  11'd0, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd99, 8'd1, 8'd1, 2'd0, NO_ENTRY, NO_ENTRY},
        // width cut to one mid-row: every pixel now ends a row
        '{STEP_CFG, REG_FRAME_WIDTH,  11'd1, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd17, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd255, 8'd255, 8'd255, 2'd0, NO_ENTRY, NO_ENTRY},
        // 2x4 frame, height cut after two rows
        '{STEP_CFG, REG_FRAME_WIDTH,  11'd2, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_FRAME_HEIGHT, 11'd4, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd5, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd6, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd7, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd8, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_CFG, REG_FRAME_HEIGHT, 11'd2, 8'd0, 8'd0, 8'd0, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd250, 8'd3, 8'd3, 2'd0, NO_ENTRY, NO_ENTRY},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd1, 8'd3, 8'd3, 2'd0, NO_ENTRY, NO_ENTRY}
    };

    localparam logic [REG_IDX_W-1:0] REG_LIST [3] =
        '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_COLOUR_MODE};
    localparam logic [APB_DATA_W-1:0] REG_RESET [3] =
        '{32'(RST_FRAME_WIDTH), 32'(RST_FRAME_HEIGHT), 32'(RST_COLOUR_MODE)};

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   push     = 1'b0;
    logic                   full;
    logic [7:0]             i_chan_a = '0;
    logic [7:0]             i_chan_b = '0;
    logic [7:0]             i_chan_c = '0;
    logic                   empty;
    logic                   pop      = 1'b0;
    logic                   o_profile_axis;
    logic [INDEX_W-1:0]     o_profile_index;
    logic [VALUE_W-1:0]     o_profile_value;
    logic                   o_last_of_run;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // predictor state
    logic [CFG_DIM_W-1:0]   cfg_width  = RST_FRAME_WIDTH;
    logic [CFG_DIM_W-1:0]   cfg_height = RST_FRAME_HEIGHT;
    logic                   cfg_colour = RST_COLOUR_MODE;
    logic [TOTAL_W-1:0]     row_sum    = '0;
    logic [TOTAL_W-1:0]     col_sum [MAX_COLS];
    bit                     col_seen [MAX_COLS];
    logic [INDEX_W-1:0]     col_pos    = '0;
    logic [INDEX_W-1:0]     row_pos    = '0;

    t_result                pending_entries [$];
    t_result                oldest_entry;
    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    int                     pop_hold       = 0;
    bit                     pop_calm       = 1'b0;
    bit                     push_calm      = 1'b0;

    image_projection_profile uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_chan_a        (i_chan_a),
        .i_chan_b        (i_chan_b),
        .i_chan_c        (i_chan_c),
        .empty           (empty),
        .pop             (pop),
        .o_profile_axis  (o_profile_axis),
        .o_profile_index (o_profile_index),
        .o_profile_value (o_profile_value),
        .o_last_of_run   (o_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] profile_scale(input logic [TOTAL_W-1:0] total);
        return cfg_colour ? VALUE_W'(total / 3) : VALUE_W'(total);
    endfunction

    function automatic void add_entry(input t_result entry);
        pending_entries.insert(pending_entries.size(), entry);
    endfunction

    // advance the profile state by one pixel; queue its entries when keep is set
    function automatic void predict_profile(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input bit keep);
        int unsigned w, h, col, pix;
        bit row_end, last_row;
        logic [TOTAL_W-1:0] ctot;
        t_result entry;
        w = eff_dim(cfg_width, MAX_COLS);
        h = eff_dim(cfg_height, MAX_ROWS);
        pix = cfg_colour ? int'(a) + int'(b) + int'(c) : int'(a);
        col = col_pos;
        row_end = (col + 1 >= w);
        last_row = (int'(row_pos) + 1 >= h);
        ctot = (row_pos == 0) ? TOTAL_W'(pix) : TOTAL_W'(col_sum[col] + pix);
        col_sum[col] = ctot;
        col_seen[col] = 1'b1;
        row_sum = TOTAL_W'(row_sum + pix);
        if (last_row && keep) begin
            entry = '{AXIS_COLUMN, INDEX_W'(col), profile_scale(ctot), !row_end};
            add_entry(entry);
        end
        if (row_end) begin
            if (keep) begin
                entry = '{AXIS_ROW, row_pos, profile_scale(row_sum), 1'b1};
                add_entry(entry);
            end
            row_sum = '0;
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = INDEX_W'(col + 1);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic feed_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                              input bit keep);
        int gap;
        gap = push_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) push_calm = !push_calm;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_chan_a <= a;
        i_chan_b <= b;
        i_chan_c <= c;
        do @(posedge i_clk); while (full);
        predict_profile(a, b, c, keep);
    endtask

    // hold off until every queued entry has come out, then let the pipe empty
    task automatic drain_profile();
        push <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DIM_W-1:0] val);
        int unsigned reach;
        logic [CFG_DIM_W-1:0] v;
        v = val;
        // mid-frame, never widen past the columns that hold a total
        if (idx == REG_FRAME_WIDTH && row_pos != 0) begin
            reach = 0;
            while (reach < MAX_COLS && col_seen[reach]) reach++;
            if (eff_dim(v, MAX_COLS) > reach) v = CFG_DIM_W'(reach);
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = v;
            REG_FRAME_HEIGHT: cfg_height = v;
            REG_COLOUR_MODE:  cfg_colour = v[0];
            default: ;
        endcase
    endtask

    // result side: random pop stalls, scoring of every transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_hold = 0;
        end else begin
            if (pop && !empty) begin
                if (pending_entries.size() == 0) begin
                    $error("unexpected entry: axis %0d index %0d value %0d",
                           o_profile_axis, o_profile_index, o_profile_value);
                    mismatch_count++;
                end else begin
                    oldest_entry = pending_entries.pop_front();
                    check_field("profile_axis", oldest_entry.axis, o_profile_axis);
                    check_field("profile_index", oldest_entry.index, o_profile_index);
                    check_field("profile_value", oldest_entry.value, o_profile_value);
                    check_field("last_of_run", oldest_entry.last, o_last_of_run);
                end
                pop_hold = pop_calm ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
            end else if (pop_hold > 0) begin
                pop_hold--;
            end
            pop <= (pop_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int burst, sent, sel;
        logic [7:0] pa, pb, pc;
        logic [APB_DATA_W-1:0] rd_word;
        for (int k = 0; k < MAX_COLS; k++) begin
            col_sum[k]  = '0;
            col_seen[k] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers read back their reset values
        for (int k = 0; k < 3; k++) begin
            @(posedge i_clk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            paddr  <= {REG_LIST[k], 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do begin
                @(negedge i_clk);
                rd_word = prdata;
            end while (!pready);
            @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            if (rd_word != REG_RESET[k]) begin
                $error("reg %0d after reset: expected %0d, got %0d", k, REG_RESET[k], rd_word);
                mismatch_count++;
            end
        end

        for (int k = 0; k < DIR_N; k++) begin
            if (DIR_STEPS[k].kind == STEP_CFG) begin
                drain_profile();
                write_reg(DIR_STEPS[k].reg_idx, DIR_STEPS[k].reg_val);
            end else begin
                if (DIR_STEPS[k].typed_n != 0) add_entry(DIR_STEPS[k].res0);
                if (DIR_STEPS[k].typed_n == 2) add_entry(DIR_STEPS[k].res1);
                feed_pixel(DIR_STEPS[k].a, DIR_STEPS[k].b, DIR_STEPS[k].c,
                           DIR_STEPS[k].typed_n == 0);
            end
        end

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain_profile();
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 15) == 0) ?
                          ($urandom_range(0, 1) ? 11'd1024 : 11'd2047) :
                          CFG_DIM_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 15) == 0) ?
                          11'd2047 : CFG_DIM_W'($urandom_range(0, 6)));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_COLOUR_MODE, CFG_DIM_W'($urandom_range(0, 1)));
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) begin
                    pa = 8'd0;   pb = 8'd0;   pc = 8'd0;
                end else if (sel == 1) begin
                    pa = 8'd255; pb = 8'd255; pc = 8'd255;
                end else begin
                    pa = 8'($urandom); pb = 8'($urandom); pc = 8'($urandom);
                end
                feed_pixel(pa, pb, pc, 1'b1);
            end
            sent += burst;
        end

        drain_profile();
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: image_projection_profile.f
sv/ipp_pkg.sv
sv/ipp_ram.sv
sv/ipp_queue.sv
sv/ipp_front.sv
sv/ipp_back.sv
sv/image_projection_profile.sv
tb/sv/tb_top.sv
